// ----- rtl/core/sbic_pkg.sv -----
// Shared constants, command item type and opcode decode for the bytecode core.
package sbic_pkg;

    localparam int STACK_DEPTH = 256;
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int SA_W        = $clog2(STACK_DEPTH);
    localparam int LOCAL_COUNT = 64;
    localparam int LA_W        = $clog2(LOCAL_COUNT);
    localparam int QUEUE_DEPTH = 4;
    localparam int QA_W        = $clog2(QUEUE_DEPTH);
    localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

    // bytecode opcodes
    localparam logic [7:0] OPC_NOP     = 8'h00;
    localparam logic [7:0] OPC_ACONST  = 8'h01;
    localparam logic [7:0] OPC_ICM1    = 8'h02;
    localparam logic [7:0] OPC_IC0     = 8'h03;
    localparam logic [7:0] OPC_IC1     = 8'h04;
    localparam logic [7:0] OPC_IC2     = 8'h05;
    localparam logic [7:0] OPC_IC3     = 8'h06;
    localparam logic [7:0] OPC_IC4     = 8'h07;
    localparam logic [7:0] OPC_IC5     = 8'h08;
    localparam logic [7:0] OPC_BIPUSH  = 8'h10;
    localparam logic [7:0] OPC_SIPUSH  = 8'h11;
    localparam logic [7:0] OPC_ILOAD   = 8'h15;
    localparam logic [7:0] OPC_ALOAD   = 8'h19;
    localparam logic [7:0] OPC_ILOAD0  = 8'h1a;
    localparam logic [7:0] OPC_ILOAD1  = 8'h1b;
    localparam logic [7:0] OPC_ILOAD2  = 8'h1c;
    localparam logic [7:0] OPC_ILOAD3  = 8'h1d;
    localparam logic [7:0] OPC_ALOAD0  = 8'h2a;
    localparam logic [7:0] OPC_ISTORE  = 8'h36;
    localparam logic [7:0] OPC_ASTORE  = 8'h3a;
    localparam logic [7:0] OPC_ISTORE0 = 8'h3b;
    localparam logic [7:0] OPC_ISTORE1 = 8'h3c;
    localparam logic [7:0] OPC_ISTORE2 = 8'h3d;
    localparam logic [7:0] OPC_ISTORE3 = 8'h3e;
    localparam logic [7:0] OPC_POP     = 8'h57;
    localparam logic [7:0] OPC_IADD    = 8'h60;
    localparam logic [7:0] OPC_ISUB    = 8'h64;
    localparam logic [7:0] OPC_IMUL    = 8'h68;
    localparam logic [7:0] OPC_IDIV    = 8'h6c;
    localparam logic [7:0] OPC_RETURN  = 8'hb1;

    // back-end commands
    localparam logic [3:0] CMD_NOP   = 4'd0;
    localparam logic [3:0] CMD_PUSH  = 4'd1;
    localparam logic [3:0] CMD_LOAD  = 4'd2;
    localparam logic [3:0] CMD_STORE = 4'd3;
    localparam logic [3:0] CMD_POP   = 4'd4;
    localparam logic [3:0] CMD_ADD   = 4'd5;
    localparam logic [3:0] CMD_SUB   = 4'd6;
    localparam logic [3:0] CMD_MUL   = 4'd7;
    localparam logic [3:0] CMD_DIV   = 4'd8;
    localparam logic [3:0] CMD_RET   = 4'd9;
    localparam logic [3:0] CMD_UNSUP = 4'd10;
    localparam logic [3:0] CMD_TRUNC = 4'd11;

    // result status codes
    localparam logic [2:0] ST_RETURNED  = 3'd0;
    localparam logic [2:0] ST_RAN_OFF   = 3'd1;
    localparam logic [2:0] ST_DIV_ZERO  = 3'd2;
    localparam logic [2:0] ST_UNDERFLOW = 3'd3;
    localparam logic [2:0] ST_OVERFLOW  = 3'd4;
    localparam logic [2:0] ST_BAD_LOCAL = 3'd5;
    localparam logic [2:0] ST_UNSUP     = 3'd6;
    localparam logic [2:0] ST_TRUNC     = 3'd7;

    typedef struct packed {
        logic [3:0]  op;
        logic [31:0] arg;
        logic        last;
    } t_cmd;

    typedef struct packed {
        logic        push;
        t_cmd        cmd;
    } t_push;

    // {unsupported, operand byte count}
    function automatic logic [2:0] classify(input logic [7:0] op);
        logic [2:0] res;
        res = 3'b000;
        case (op)
            OPC_BIPUSH, OPC_ILOAD, OPC_ALOAD, OPC_ISTORE, OPC_ASTORE: res = 3'b001;
            OPC_SIPUSH: res = 3'b010;
            OPC_NOP, OPC_ACONST, OPC_ICM1, OPC_IC0, OPC_IC1, OPC_IC2, OPC_IC3,
            OPC_IC4, OPC_IC5, OPC_ILOAD0, OPC_ILOAD1, OPC_ILOAD2, OPC_ILOAD3,
            OPC_ALOAD0, OPC_ISTORE0, OPC_ISTORE1, OPC_ISTORE2, OPC_ISTORE3,
            OPC_POP, OPC_IADD, OPC_ISUB, OPC_IMUL, OPC_IDIV, OPC_RETURN: res = 3'b000;
            default: res = 3'b100;
        endcase
        return res;
    endfunction

    // opcode plus gathered operand bytes to a back-end command (last left clear)
    function automatic t_cmd decode(input logic [7:0] op, input logic [15:0] g);
        t_cmd c;
        c.op   = CMD_UNSUP;
        c.arg  = '0;
        c.last = 1'b0;
        case (op)
            OPC_NOP:    c.op = CMD_NOP;
            OPC_ACONST: c.op = CMD_PUSH;
            OPC_ICM1, OPC_IC0, OPC_IC1, OPC_IC2, OPC_IC3, OPC_IC4, OPC_IC5: begin
                c.op  = CMD_PUSH;
                c.arg = {24'd0, op} - 32'd3;
            end
            OPC_BIPUSH: begin
                c.op  = CMD_PUSH;
                c.arg = {{24{g[7]}}, g[7:0]};
            end
            OPC_SIPUSH: begin
                c.op  = CMD_PUSH;
                c.arg = {{16{g[15]}}, g};
            end
            OPC_ILOAD, OPC_ALOAD: begin
                c.op  = CMD_LOAD;
                c.arg = {24'd0, g[7:0]};
            end
            OPC_ILOAD0, OPC_ILOAD1, OPC_ILOAD2, OPC_ILOAD3: begin
                c.op  = CMD_LOAD;
                c.arg = {24'd0, op - OPC_ILOAD0};
            end
            OPC_ALOAD0: c.op = CMD_LOAD;
            OPC_ISTORE, OPC_ASTORE: begin
                c.op  = CMD_STORE;
                c.arg = {24'd0, g[7:0]};
            end
            OPC_ISTORE0, OPC_ISTORE1, OPC_ISTORE2, OPC_ISTORE3: begin
                c.op  = CMD_STORE;
                c.arg = {24'd0, op - OPC_ISTORE0};
            end
            OPC_POP:    c.op = CMD_POP;
            OPC_IADD:   c.op = CMD_ADD;
            OPC_ISUB:   c.op = CMD_SUB;
            OPC_IMUL:   c.op = CMD_MUL;
            OPC_IDIV:   c.op = CMD_DIV;
            OPC_RETURN: c.op = CMD_RET;
            default:    c.op = CMD_UNSUP;
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/core/sbic_front.sv -----
// Front end: takes code bytes, gathers inline operands, emits decoded commands.
module sbic_front import sbic_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic       i_full,
    input  logic [7:0] i_code_byte,
    input  logic       i_last_byte,
    output t_push      o_push
);

    logic [1:0]  r_left;
    logic [1:0]  n_left;
    logic [7:0]  r_op;
    logic [15:0] r_gather;
    logic [15:0] w_gather;
    logic [2:0]  w_class;
    logic        w_take;

    assign w_take   = i_valid && !i_full;
    assign w_class  = classify(i_code_byte);
    assign w_gather = {r_gather[7:0], i_code_byte};

    always_comb begin
        o_push.push     = 1'b0;
        o_push.cmd      = decode(i_code_byte, 16'd0);
        o_push.cmd.last = i_last_byte;
        n_left          = r_left;
        if (r_left != 2'd0) begin
            n_left = r_left - 2'd1;
            if (n_left != 2'd0) begin
                o_push.push   = i_last_byte;
                o_push.cmd.op = CMD_TRUNC;
            end else begin
                o_push.push     = 1'b1;
                o_push.cmd      = decode(r_op, w_gather);
                o_push.cmd.last = i_last_byte;
            end
        end else if (w_class[2]) begin
            o_push.push   = 1'b1;
            o_push.cmd.op = CMD_UNSUP;
        end else if (w_class[1:0] != 2'd0) begin
            n_left        = w_class[1:0];
            o_push.push   = i_last_byte;
            o_push.cmd.op = CMD_TRUNC;
        end else begin
            o_push.push = 1'b1;
        end
        o_push.push = o_push.push && w_take;
        if (i_last_byte) begin
            n_left = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 2'd0;
        end else if (w_take) begin
            r_left <= n_left;
            if (r_left == 2'd0) begin
                r_op     <= i_code_byte;
                r_gather <= 16'd0;
            end else begin
                r_gather <= w_gather;
            end
        end
    end

endmodule

// ----- rtl/core/sbic_queue.sv -----
// Short command queue between front and back ends.
module sbic_queue import sbic_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_push           i_push,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_nonempty,
    output logic [QC_W-1:0] o_count,
    output t_cmd            o_cmd
);

    t_cmd            r_mem [QUEUE_DEPTH];
    logic [QA_W-1:0] r_wr;
    logic [QA_W-1:0] r_rd;
    logic [QC_W-1:0] r_count;

    assign o_full     = r_count == QC_W'(QUEUE_DEPTH);
    assign o_nonempty = r_count != '0;
    assign o_count    = r_count;
    assign o_cmd      = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push.push) begin
                r_mem[r_wr] <= i_push.cmd;
                r_wr        <= r_wr + QA_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QA_W'(1);
            end
            case ({i_push.push, i_pop})
                2'b10:   r_count <= r_count + QC_W'(1);
                2'b01:   r_count <= r_count - QC_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- rtl/core/sbic_back.sv -----
// Back end: operand stack, locals, ALU, iterative divider and result register.
module sbic_back import sbic_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_nonempty,
    input  t_cmd               i_cmd,
    output logic               o_pop,
    input  logic               i_stall,
    output logic               o_valid,
    output logic [2:0]         o_status,
    output logic [8:0]         o_stack_depth,
    output logic signed [31:0] o_top_value
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;

    logic [1:0]       r_state;
    t_cmd             r_cmd;
    logic [SP_W-1:0]  r_sp;
    logic [31:0]      r_tos;
    logic             r_halted;
    logic [31:0]      m_stack [STACK_DEPTH];
    logic [31:0]      m_loc [LOCAL_COUNT];
    logic [LOCAL_COUNT-1:0] r_lvalid;
    logic [31:0]      r_mrd;
    logic [31:0]      r_lrd;
    logic             r_ovalid;
    logic [2:0]       r_status;
    logic [8:0]       r_depth;
    logic [31:0]      r_top;
    logic [31:0]      r_dq;
    logic [31:0]      r_drem;
    logic [31:0]      r_dd;
    logic [4:0]       r_dcnt;
    logic             r_dneg;

    logic             w_exec;
    logic             w_res;
    logic [2:0]       w_code;
    logic [SP_W-1:0]  w_sp;
    logic [31:0]      w_tos;
    logic             w_push;
    logic [31:0]      w_pval;
    logic             w_swe;
    logic             w_lwe;
    logic             w_div;
    logic             w_idx_ok;
    logic [LA_W-1:0]  w_lidx;
    logic [31:0]      w_lval;
    logic [32:0]      w_rem2;
    logic [32:0]      w_diff;
    logic [31:0]      w_qn;
    logic [31:0]      w_remn;
    logic             w_fin;
    logic             w_fres;
    logic [2:0]       w_fcode;
    logic [SP_W-1:0]  w_fsp;
    logic [31:0]      w_ftos;

    assign o_pop    = i_nonempty && r_state == S_IDLE && (!r_ovalid || !i_stall);
    assign w_exec   = r_state == S_EXEC && !r_halted;
    assign w_idx_ok = {1'b0, r_cmd.arg[7:0]} < 9'(LOCAL_COUNT);
    assign w_lidx   = r_cmd.arg[LA_W-1:0];
    assign w_lval   = r_lvalid[w_lidx] ? r_lrd : 32'd0;

    always_comb begin
        w_res  = 1'b0;
        w_code = ST_RAN_OFF;
        w_sp   = r_sp;
        w_tos  = r_tos;
        w_push = 1'b0;
        w_pval = r_cmd.arg;
        w_swe  = 1'b0;
        w_lwe  = 1'b0;
        w_div  = 1'b0;
        case (r_cmd.op)
            CMD_NOP: ;
            CMD_PUSH: w_push = 1'b1;
            CMD_LOAD: begin
                if (!w_idx_ok) begin
                    w_res  = 1'b1;
                    w_code = ST_BAD_LOCAL;
                end else begin
                    w_push = 1'b1;
                    w_pval = w_lval;
                end
            end
            CMD_STORE: begin
                if (!w_idx_ok) begin
                    w_res  = 1'b1;
                    w_code = ST_BAD_LOCAL;
                end else if (r_sp == '0) begin
                    w_res  = 1'b1;
                    w_code = ST_UNDERFLOW;
                end else begin
                    w_lwe = 1'b1;
                    w_sp  = r_sp - SP_W'(1);
                    w_tos = r_mrd;
                end
            end
            CMD_POP: begin
                if (r_sp == '0) begin
                    w_res  = 1'b1;
                    w_code = ST_UNDERFLOW;
                end else begin
                    w_sp  = r_sp - SP_W'(1);
                    w_tos = r_mrd;
                end
            end
            CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
                if (r_sp < SP_W'(2)) begin
                    w_res  = 1'b1;
                    w_code = ST_UNDERFLOW;
                end else if (r_cmd.op == CMD_DIV) begin
                    if (r_tos == 32'd0) begin
                        w_res  = 1'b1;
                        w_code = ST_DIV_ZERO;
                    end else begin
                        w_div = 1'b1;
                    end
                end else begin
                    w_sp = r_sp - SP_W'(1);
                    case (r_cmd.op)
                        CMD_ADD: w_tos = r_mrd + r_tos;
                        CMD_SUB: w_tos = r_mrd - r_tos;
                        default: w_tos = r_mrd * r_tos;
                    endcase
                end
            end
            CMD_RET: begin
                w_res  = 1'b1;
                w_code = ST_RETURNED;
            end
            CMD_UNSUP: begin
                w_res  = 1'b1;
                w_code = ST_UNSUP;
            end
            CMD_TRUNC: begin
                w_res  = 1'b1;
                w_code = ST_TRUNC;
            end
            default: begin
                w_res  = 1'b1;
                w_code = ST_UNSUP;
            end
        endcase
        if (w_push) begin
            if (r_sp == SP_W'(STACK_DEPTH)) begin
                w_res  = 1'b1;
                w_code = ST_OVERFLOW;
            end else begin
                w_swe = r_sp != '0;
                w_sp  = r_sp + SP_W'(1);
                w_tos = w_pval;
            end
        end
    end

    // restoring divider step on magnitudes, one quotient bit per cycle
    assign w_rem2 = {r_drem, r_dq[31]};
    assign w_diff = w_rem2 - {1'b0, r_dd};
    assign w_qn   = {r_dq[30:0], !w_diff[32]};
    assign w_remn = w_diff[32] ? w_rem2[31:0] : w_diff[31:0];

    always_comb begin
        w_fin   = 1'b0;
        w_fres  = w_res;
        w_fcode = w_code;
        w_fsp   = w_sp;
        w_ftos  = w_tos;
        if (w_exec) begin
            w_fin = !w_div;
        end else if (r_state == S_DIV && r_dcnt == 5'd31) begin
            w_fin  = 1'b1;
            w_fres = 1'b0;
            w_fsp  = r_sp - SP_W'(1);
            w_ftos = r_dneg ? (32'd0 - w_qn) : w_qn;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_exec && w_swe) begin
            m_stack[SA_W'(r_sp - SP_W'(1))] <= r_tos;
        end
        if (o_pop) begin
            r_mrd <= m_stack[SA_W'(r_sp - SP_W'(2))];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_exec && w_lwe) begin
            m_loc[w_lidx] <= r_tos;
        end
        if (o_pop) begin
            r_lrd <= m_loc[i_cmd.arg[LA_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_sp     <= '0;
            r_halted <= 1'b0;
            r_ovalid <= 1'b0;
            r_lvalid <= '0;
        end else begin
            if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_cmd   <= i_cmd;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_state <= S_IDLE;
                    if (r_halted) begin
                        if (r_cmd.last) begin
                            r_sp     <= '0;
                            r_lvalid <= '0;
                            r_halted <= 1'b0;
                        end
                    end else if (w_div) begin
                        r_state <= S_DIV;
                        r_dneg  <= r_mrd[31] ^ r_tos[31];
                        r_dq    <= r_mrd[31] ? (32'd0 - r_mrd) : r_mrd;
                        r_dd    <= r_tos[31] ? (32'd0 - r_tos) : r_tos;
                        r_drem  <= 32'd0;
                        r_dcnt  <= 5'd0;
                    end
                end
                S_DIV: begin
                    r_dq   <= w_qn;
                    r_drem <= w_remn;
                    r_dcnt <= r_dcnt + 5'd1;
                    if (r_dcnt == 5'd31) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (w_fin) begin
                r_sp  <= w_fsp;
                r_tos <= w_ftos;
                if (w_exec && w_lwe) begin
                    r_lvalid[w_lidx] <= 1'b1;
                end
                if (w_fres || r_cmd.last) begin
                    r_ovalid <= 1'b1;
                    r_status <= w_fres ? w_fcode : ST_RAN_OFF;
                    r_depth  <= 9'(w_fsp);
                    r_top    <= (w_fsp != '0) ? w_ftos : 32'd0;
                    if (r_cmd.last) begin
                        r_sp     <= '0;
                        r_lvalid <= '0;
                    end else begin
                        r_halted <= 1'b1;
                    end
                end
            end
        end
    end

    assign o_valid       = r_ovalid;
    assign o_status      = r_status;
    assign o_stack_depth = r_depth;
    assign o_top_value   = r_top;

endmodule

// ----- rtl/core/stack_bytecode_integer_core.sv -----
// Integer stack bytecode core: one code byte per item, one result per method end.
// Front end takes one byte per cycle while the command queue has room.
// Back end: each command is dispatched (with stack/local read), then executed;
// idiv then stays in the bit-serial divider. The result is registered at the end
// of execute, or of the last divide step for idiv.
// Synchronous active-low reset empties the queue, clears stack pointer, local
// valid bits and halt; no clearing pass.
module stack_bytecode_integer_core import sbic_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_code_byte,
    input  logic               i_last_byte,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [2:0]         o_status,
    output logic [8:0]         o_stack_depth,
    output logic signed [31:0] o_top_value
);

    t_push           w_push;
    t_cmd            w_qcmd;
    logic            w_full;
    logic            w_nonempty;
    logic            w_pop;
    logic [QC_W-1:0] w_count;

    assign o_stall = w_full;

    // byte gathering and decode; every last byte yields a command
    sbic_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_full      (w_full),
        .i_code_byte (i_code_byte),
        .i_last_byte (i_last_byte),
        .o_push      (w_push)
    );

    // decouples byte intake from slow back-end commands
    sbic_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_pop      (w_pop),
        .o_full     (w_full),
        .o_nonempty (w_nonempty),
        .o_count    (w_count),
        .o_cmd      (w_qcmd)
    );

    // execution: stack, locals, divider; halts after an error until the last item
    sbic_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_nonempty    (w_nonempty),
        .i_cmd         (w_qcmd),
        .o_pop         (w_pop),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_stack_depth (o_stack_depth),
        .o_top_value   (o_top_value)
    );

    a_depth_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stack_depth <= 9'(STACK_DEPTH))
        else $error("stack depth beyond capacity");

    a_empty_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_stack_depth == 9'd0) |-> o_top_value == 32'sd0)
        else $error("empty stack with nonzero top");

    a_queue_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= QC_W'(QUEUE_DEPTH))
        else $error("queue count overrun");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_count != '0)
        else $error("pop from empty queue");

endmodule
